[hdl/gamepad_input_conditioner_unit_assert.svh]
// Assertion macros for the gamepad input conditioner checker.
// Expects clk and arst_n in the scope of each use.
`ifndef GAMEPAD_INPUT_CONDITIONER_UNIT_ASSERT_SVH
`define GAMEPAD_INPUT_CONDITIONER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define GIC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gic assertion failed");

// next-cycle implication, off during reset
`define GIC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gic assertion failed");

`endif

[hdl/gic_pkg.sv]
// Shared types, constants and the edge tracker function of the gamepad input conditioner.
// No dependencies.
package gic_pkg;

	localparam int NUM_BTN = 14;
	localparam int NUM_DIR = 8;
	localparam int NUM_TRG = 2;
	localparam int AXIS_W  = 16;
	localparam int DZ_W    = 15;
	localparam int TRG_W   = 8;
	localparam int BTN_W   = 16;
	localparam int CFG_W   = 15;

	localparam logic [1:0] ST_OFF      = 2'd0;
	localparam logic [1:0] ST_PRESSED  = 2'd1;
	localparam logic [1:0] ST_HELD     = 2'd2;
	localparam logic [1:0] ST_RELEASED = 2'd3;

	localparam logic CFG_STICK_DZ = 1'b0;
	localparam logic CFG_TRIG_DZ  = 1'b1;

	localparam logic [DZ_W-1:0]  STICK_DZ_RST = 15'd7864;
	localparam logic [TRG_W-1:0] TRIG_DZ_RST  = 8'd61;

	localparam logic signed [AXIS_W-1:0] AXIS_MIN     = 16'sh8000;
	localparam logic signed [AXIS_W-1:0] AXIS_MIN_CLP = 16'sh8001;

	localparam logic [3:0] BTN_MAP [NUM_BTN] = '{
		4'd12, 4'd13, 4'd14, 4'd15, 4'd9, 4'd10, 4'd5,
		4'd4, 4'd6, 4'd7, 4'd2, 4'd3, 4'd0, 4'd1
	};

	typedef struct packed {
		logic left;
		logic right;
		logic down;
		logic up;
	} dir_lvl_t;

	typedef struct packed {
		dir_lvl_t                   dir;
		logic signed [AXIS_W-1:0]   x;
		logic signed [AXIS_W-1:0]   y;
	} stick_res_t;

	function automatic logic [1:0] track_next(input logic level, input logic [1:0] old);
		logic was_down;
		was_down = old[1] ^ old[0];
		if (level) begin
			return was_down ? ST_HELD : ST_PRESSED;
		end
		return was_down ? ST_RELEASED : ST_OFF;
	endfunction

endpackage

[hdl/gic_stick.sv]
// Dead zone and direction decode for one analog stick.
// Depends on gic_pkg.
module gic_stick (
	input  logic signed [gic_pkg::AXIS_W-1:0] x,
	input  logic signed [gic_pkg::AXIS_W-1:0] y,
	input  logic        [gic_pkg::DZ_W-1:0]   dz,
	output gic_pkg::stick_res_t               res
);
	import gic_pkg::*;

	logic signed [AXIS_W:0] x_e;
	logic signed [AXIS_W:0] y_e;
	logic signed [AXIS_W:0] dz_p;
	logic signed [AXIS_W:0] dz_n;
	logic x_lt, x_gt, y_lt, y_gt;
	logic neutral;

	always_comb begin
		x_e  = {x[AXIS_W-1], x};
		y_e  = {y[AXIS_W-1], y};
		dz_p = {{(AXIS_W+1-DZ_W){1'b0}}, dz};
		dz_n = -dz_p;
		x_lt = x_e < dz_n;
		x_gt = x_e > dz_p;
		y_lt = y_e < dz_n;
		y_gt = y_e > dz_p;
		neutral = !(x_lt || x_gt || y_lt || y_gt);
		res.dir.left  = x_lt;
		res.dir.right = x_gt;
		res.dir.down  = y_lt;
		res.dir.up    = y_gt;
		res.x = neutral ? '0 : x;
		res.y = neutral ? '0 : y;
	end

endmodule

[hdl/gamepad_input_conditioner_unit.sv]
// Top level of the gamepad input conditioner: input stage, trackers and held levels.
// Depends on gic_pkg and gic_stick.
//
// Usage:
// - Config port: cfg_we writes cfg_data into register cfg_index (0 stick dead
//   zone, 1 trigger dead zone) at the clock edge. Write only while idle.
// - Input channel: a request moves when in_valid is high and in_stall is low.
//   Each request is one polled frame; poll_ok low repeats the held result.
// - Output channel: one result per request, moved when out_valid is high and
//   out_stall is low.
// - Registers: an accepted request goes to the input register, then to the result
//   register, which raises out_valid (one input register, one result register).
// - Throughput: one request per cycle unless stalled; the tracker update is a
//   single pass of short compare logic between input and result registers.
// - Stall: a stalled result holds; the input register still takes one more
//   request, then in_stall rises until the result is taken.
// - Reset: all trackers off, held levels zero, dead zones 7864 and 61,
//   both channels empty.
module gamepad_input_conditioner_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic        [gic_pkg::CFG_W-1:0]   cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               poll_ok,
	input  logic        [gic_pkg::BTN_W-1:0]   button_bits,
	input  logic signed [gic_pkg::AXIS_W-1:0]  left_x,
	input  logic signed [gic_pkg::AXIS_W-1:0]  left_y,
	input  logic signed [gic_pkg::AXIS_W-1:0]  right_x,
	input  logic signed [gic_pkg::AXIS_W-1:0]  right_y,
	input  logic        [gic_pkg::TRG_W-1:0]   left_trigger,
	input  logic        [gic_pkg::TRG_W-1:0]   right_trigger,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic        [2*gic_pkg::NUM_BTN-1:0] button_states,
	output logic        [2*gic_pkg::NUM_DIR-1:0] direction_states,
	output logic        [2*gic_pkg::NUM_TRG-1:0] trigger_states,
	output logic signed [gic_pkg::AXIS_W-1:0]  out_left_x,
	output logic signed [gic_pkg::AXIS_W-1:0]  out_left_y,
	output logic signed [gic_pkg::AXIS_W-1:0]  out_right_x,
	output logic signed [gic_pkg::AXIS_W-1:0]  out_right_y,
	output logic        [gic_pkg::TRG_W-1:0]   out_left_trigger,
	output logic        [gic_pkg::TRG_W-1:0]   out_right_trigger
);
	import gic_pkg::*;

	logic [DZ_W-1:0]  stick_dz_q;
	logic [TRG_W-1:0] trig_dz_q;

	logic                     valid_s1;
	logic                     poll_ok_s1;
	logic [BTN_W-1:0]         button_bits_s1;
	logic signed [AXIS_W-1:0] left_x_s1;
	logic signed [AXIS_W-1:0] left_y_s1;
	logic signed [AXIS_W-1:0] right_x_s1;
	logic signed [AXIS_W-1:0] right_y_s1;
	logic [TRG_W-1:0]         left_trg_s1;
	logic [TRG_W-1:0]         right_trg_s1;

	logic                     out_valid_q;
	logic [1:0]               btn_trk_q [NUM_BTN];
	logic [1:0]               dir_trk_q [NUM_DIR];
	logic [1:0]               trg_trk_q [NUM_TRG];
	logic signed [AXIS_W-1:0] lx_q, ly_q, rx_q, ry_q;
	logic [TRG_W-1:0]         lt_q, rt_q;

	logic                     adv;
	logic                     in_acc;
	logic                     upd;
	logic signed [AXIS_W-1:0] lx_c, ly_c;
	stick_res_t               left_res, right_res;
	logic [NUM_DIR-1:0]       dir_lvl;
	logic                     lt_on, rt_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_dz_q <= STICK_DZ_RST;
			trig_dz_q  <= TRIG_DZ_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STICK_DZ: stick_dz_q <= cfg_data[DZ_W-1:0];
				CFG_TRIG_DZ:  trig_dz_q  <= cfg_data[TRG_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;
	assign upd      = valid_s1 && adv && poll_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			poll_ok_s1     <= poll_ok;
			button_bits_s1 <= button_bits;
			left_x_s1      <= left_x;
			left_y_s1      <= left_y;
			right_x_s1     <= right_x;
			right_y_s1     <= right_y;
			left_trg_s1    <= left_trigger;
			right_trg_s1   <= right_trigger;
		end
	end

	assign lx_c = (left_x_s1 == AXIS_MIN) ? AXIS_MIN_CLP : left_x_s1;
	assign ly_c = (left_y_s1 == AXIS_MIN) ? AXIS_MIN_CLP : left_y_s1;

	gic_stick u_left (
		.x   (lx_c),
		.y   (ly_c),
		.dz  (stick_dz_q),
		.res (left_res)
	);

	gic_stick u_right (
		.x   (right_x_s1),
		.y   (right_y_s1),
		.dz  (stick_dz_q),
		.res (right_res)
	);

	assign dir_lvl = {right_res.dir.up, right_res.dir.down, right_res.dir.right,
		right_res.dir.left, left_res.dir.up, left_res.dir.down, left_res.dir.right,
		left_res.dir.left};
	assign lt_on = left_trg_s1 > trig_dz_q;
	assign rt_on = right_trg_s1 > trig_dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BTN; i++) begin
				btn_trk_q[i] <= ST_OFF;
			end
			for (int i = 0; i < NUM_DIR; i++) begin
				dir_trk_q[i] <= ST_OFF;
			end
			for (int i = 0; i < NUM_TRG; i++) begin
				trg_trk_q[i] <= ST_OFF;
			end
			lx_q <= '0;
			ly_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			lt_q <= '0;
			rt_q <= '0;
		end else if (upd) begin
			for (int i = 0; i < NUM_BTN; i++) begin
				btn_trk_q[i] <= track_next(button_bits_s1[BTN_MAP[i]], btn_trk_q[i]);
			end
			for (int i = 0; i < NUM_DIR; i++) begin
				dir_trk_q[i] <= track_next(dir_lvl[i], dir_trk_q[i]);
			end
			trg_trk_q[0] <= track_next(lt_on, trg_trk_q[0]);
			trg_trk_q[1] <= track_next(rt_on, trg_trk_q[1]);
			lx_q <= left_res.x;
			ly_q <= left_res.y;
			rx_q <= right_res.x;
			ry_q <= right_res.y;
			lt_q <= lt_on ? left_trg_s1 : '0;
			rt_q <= rt_on ? right_trg_s1 : '0;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_BTN; i++) begin
			button_states[2*i +: 2] = btn_trk_q[i];
		end
		for (int i = 0; i < NUM_DIR; i++) begin
			direction_states[2*i +: 2] = dir_trk_q[i];
		end
		for (int i = 0; i < NUM_TRG; i++) begin
			trigger_states[2*i +: 2] = trg_trk_q[i];
		end
	end

	assign out_valid         = out_valid_q;
	assign out_left_x        = lx_q;
	assign out_left_y        = ly_q;
	assign out_right_x       = rx_q;
	assign out_right_y       = ry_q;
	assign out_left_trigger  = lt_q;
	assign out_right_trigger = rt_q;

endmodule

[hdl/gic_checker.sv]
// Port-level checks of the gamepad input conditioner, bound to the top level.
// Depends on gic_pkg and gamepad_input_conditioner_unit_assert.svh.
`include "gamepad_input_conditioner_unit_assert.svh"
module gic_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic        [2*gic_pkg::NUM_BTN-1:0] button_states,
	input logic        [2*gic_pkg::NUM_DIR-1:0] direction_states,
	input logic        [2*gic_pkg::NUM_TRG-1:0] trigger_states,
	input logic signed [gic_pkg::AXIS_W-1:0]  out_left_x,
	input logic signed [gic_pkg::AXIS_W-1:0]  out_left_y,
	input logic        [gic_pkg::TRG_W-1:0]   out_left_trigger
);
	import gic_pkg::*;

	logic left_down;
	logic left_lvl;
	logic lt_down;

	assign left_down = (direction_states[1] ^ direction_states[0])
		|| (direction_states[3] ^ direction_states[2])
		|| (direction_states[5] ^ direction_states[4])
		|| (direction_states[7] ^ direction_states[6]);
	assign left_lvl  = (out_left_x != '0) || (out_left_y != '0);
	assign lt_down   = trigger_states[1] ^ trigger_states[0];

	`GIC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(button_states))
	`GIC_ASSERT_IMP(a_left_clamp, out_valid, out_left_x != AXIS_MIN && out_left_y != AXIS_MIN)
	`GIC_ASSERT_IMP(a_left_dir_lvl, out_valid, left_down == left_lvl)
	`GIC_ASSERT_IMP(a_lt_lvl, out_valid, lt_down == (out_left_trigger != '0))

endmodule

bind gamepad_input_conditioner_unit gic_checker u_gic_checker (.*);

[test/gamepad_input_conditioner_unit_test.sv]
// Self-checking bench for gamepad_input_conditioner_unit: directed and random poll frames,
// predicted trackers, dead zones and held levels, with random idling on both channels.
// Depends on gic_pkg and the block's RTL; reads no files.
module gamepad_input_conditioner_unit_test;
	import gic_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 200;
	localparam int RAW_BIT_OF [NUM_BTN] = '{12, 13, 14, 15, 9, 10, 5, 4, 6, 7, 2, 3, 0, 1};

	typedef struct packed {
		logic                      poll_ok;
		logic [BTN_W-1:0]          buttons;
		logic signed [AXIS_W-1:0]  lx, ly, rx, ry;
		logic [TRG_W-1:0]          lt, rt;
	} poll_frame_t;

	typedef struct packed {
		logic [2*NUM_BTN-1:0]      buttons;
		logic [2*NUM_DIR-1:0]      dirs;
		logic [2*NUM_TRG-1:0]      trigs;
		logic signed [AXIS_W-1:0]  lx, ly, rx, ry;
		logic [TRG_W-1:0]          lt, rt;
	} report_t;

	class pad_report_board;
		logic [DZ_W-1:0]           stick_dz;
		logic [TRG_W-1:0]          trig_dz;
		logic [1:0]                btn_trk [NUM_BTN];
		logic [1:0]                dir_trk [NUM_DIR];
		logic [1:0]                trg_trk [NUM_TRG];
		logic signed [AXIS_W-1:0]  axis_lvl [4];
		logic [TRG_W-1:0]          trg_lvl [NUM_TRG];
		report_t                   pending_reports [$];
		int                        errors;
		int                        reports_ok;
		int                        polls;
		int                        failed_polls;

		function new();
			stick_dz = 15'd7864;
			trig_dz = 8'd61;
			foreach (btn_trk[i]) btn_trk[i] = ST_OFF;
			foreach (dir_trk[i]) dir_trk[i] = ST_OFF;
			foreach (trg_trk[i]) trg_trk[i] = ST_OFF;
			foreach (axis_lvl[i]) axis_lvl[i] = '0;
			foreach (trg_lvl[i]) trg_lvl[i] = '0;
			errors = 0;
			reports_ok = 0;
			polls = 0;
			failed_polls = 0;
		endfunction

		function void set_reg(logic idx, logic [CFG_W-1:0] data);
			if (idx == CFG_STICK_DZ) begin
				stick_dz = data[DZ_W-1:0];
			end else if (idx == CFG_TRIG_DZ) begin
				trig_dz = data[TRG_W-1:0];
			end
		endfunction

		function logic [1:0] advance(logic level, logic [1:0] cur);
			logic was_down;
			was_down = (cur == ST_PRESSED) || (cur == ST_HELD);
			if (level) begin
				return was_down ? ST_HELD : ST_PRESSED;
			end
			return was_down ? ST_RELEASED : ST_OFF;
		endfunction

		function void update_stick(int x, int y, int base, int lvl);
			int dz;
			int ax;
			int ay;
			dz = int'(stick_dz);
			ax = x < 0 ? -x : x;
			ay = y < 0 ? -y : y;
			if (ax <= dz && ay <= dz) begin
				axis_lvl[lvl] = '0;
				axis_lvl[lvl+1] = '0;
			end else begin
				axis_lvl[lvl] = 16'(x);
				axis_lvl[lvl+1] = 16'(y);
			end
			dir_trk[base]   = advance(x < -dz, dir_trk[base]);
			dir_trk[base+1] = advance(x > dz, dir_trk[base+1]);
			dir_trk[base+2] = advance(y < -dz, dir_trk[base+2]);
			dir_trk[base+3] = advance(y > dz, dir_trk[base+3]);
		endfunction

		function void note_poll(poll_frame_t f);
			int lx;
			int ly;
			logic [TRG_W-1:0] raw;
			logic on;
			report_t r;
			polls++;
			if (f.poll_ok) begin
				for (int i = 0; i < NUM_BTN; i++) begin
					btn_trk[i] = advance(f.buttons[RAW_BIT_OF[i]], btn_trk[i]);
				end
				lx = f.lx;
				ly = f.ly;
				if (lx == -32768) lx = -32767;
				if (ly == -32768) ly = -32767;
				update_stick(lx, ly, 0, 0);
				update_stick(int'(f.rx), int'(f.ry), 4, 2);
				for (int i = 0; i < NUM_TRG; i++) begin
					raw = (i == 0) ? f.lt : f.rt;
					on = raw > trig_dz;
					trg_lvl[i] = on ? raw : '0;
					trg_trk[i] = advance(on, trg_trk[i]);
				end
			end else begin
				failed_polls++;
			end
			for (int i = 0; i < NUM_BTN; i++) r.buttons[2*i +: 2] = btn_trk[i];
			for (int i = 0; i < NUM_DIR; i++) r.dirs[2*i +: 2] = dir_trk[i];
			for (int i = 0; i < NUM_TRG; i++) r.trigs[2*i +: 2] = trg_trk[i];
			r.lx = axis_lvl[0];
			r.ly = axis_lvl[1];
			r.rx = axis_lvl[2];
			r.ry = axis_lvl[3];
			r.lt = trg_lvl[0];
			r.rt = trg_lvl[1];
			pending_reports = {pending_reports, r};
		endfunction

		function string report_text(report_t r);
			return $sformatf("btn=%07h dir=%04h trg=%01h lx=%0d ly=%0d rx=%0d ry=%0d lt=%0d rt=%0d",
				r.buttons, r.dirs, r.trigs, r.lx, r.ly, r.rx, r.ry, r.lt, r.rt);
		endfunction

		function void check_report(report_t got);
			report_t want;
			string bad;
			if (pending_reports.size() == 0) begin
				errors++;
				if (errors <= 10) $display("report with none pending: %s", report_text(got));
				return;
			end
			want = pending_reports.pop_front();
			bad = "";
			if (got.buttons != want.buttons) bad = {bad, " button_states"};
			if (got.dirs != want.dirs) bad = {bad, " direction_states"};
			if (got.trigs != want.trigs) bad = {bad, " trigger_states"};
			if (got.lx != want.lx) bad = {bad, " out_left_x"};
			if (got.ly != want.ly) bad = {bad, " out_left_y"};
			if (got.rx != want.rx) bad = {bad, " out_right_x"};
			if (got.ry != want.ry) bad = {bad, " out_right_y"};
			if (got.lt != want.lt) bad = {bad, " out_left_trigger"};
			if (got.rt != want.rt) bad = {bad, " out_right_trigger"};
			if (bad != "") begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch on%s", bad);
					$display("  expected %s", report_text(want));
					$display("  actual   %s", report_text(got));
				end
			end else begin
				reports_ok++;
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic                        cfg_index = CFG_STICK_DZ;
	logic [CFG_W-1:0]            cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        poll_ok = 1'b0;
	logic [BTN_W-1:0]            button_bits = '0;
	logic signed [AXIS_W-1:0]    left_x = '0;
	logic signed [AXIS_W-1:0]    left_y = '0;
	logic signed [AXIS_W-1:0]    right_x = '0;
	logic signed [AXIS_W-1:0]    right_y = '0;
	logic [TRG_W-1:0]            left_trigger = '0;
	logic [TRG_W-1:0]            right_trigger = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [2*NUM_BTN-1:0]        button_states;
	logic [2*NUM_DIR-1:0]        direction_states;
	logic [2*NUM_TRG-1:0]        trigger_states;
	logic signed [AXIS_W-1:0]    out_left_x;
	logic signed [AXIS_W-1:0]    out_left_y;
	logic signed [AXIS_W-1:0]    out_right_x;
	logic signed [AXIS_W-1:0]    out_right_y;
	logic [TRG_W-1:0]            out_left_trigger;
	logic [TRG_W-1:0]            out_right_trigger;

	pad_report_board board;
	poll_frame_t     last_poll = '0;
	report_t         seen;
	bit              tx_idle = 1'b1;
	bit              rx_idle = 1'b1;
	int              hold_asked = 0;
	int              hold_done = 0;
	int              hold_left = 0;
	int              stall_left = 0;
	int              cycle_count = 0;
	int              settings = 0;

	gamepad_input_conditioner_unit u_top (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL gamepad_input_conditioner_unit");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.buttons = button_states;
			seen.dirs = direction_states;
			seen.trigs = trigger_states;
			seen.lx = out_left_x;
			seen.ly = out_left_y;
			seen.rx = out_right_x;
			seen.ry = out_right_y;
			seen.lt = out_left_trigger;
			seen.rt = out_right_trigger;
			board.check_report(seen);
		end
		if (hold_asked != hold_done) begin
			hold_done = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (rx_idle && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_poll(poll_frame_t f);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		poll_ok <= f.poll_ok;
		button_bits <= f.buttons;
		left_x <= f.lx;
		left_y <= f.ly;
		right_x <= f.rx;
		right_y <= f.ry;
		left_trigger <= f.lt;
		right_trigger <= f.rt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_poll(f);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.set_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_dead_zones(logic [DZ_W-1:0] sdz, logic [TRG_W-1:0] tdz);
		wait_drained();
		write_reg(CFG_STICK_DZ, sdz);
		write_reg(CFG_TRIG_DZ, {7'($urandom), tdz});
		settings++;
	endtask

	function automatic poll_frame_t poll_of(bit ok, logic [BTN_W-1:0] b, int lx, int ly,
			int rx, int ry, int lt, int rt);
		poll_frame_t f;
		f.poll_ok = ok;
		f.buttons = b;
		f.lx = 16'(lx);
		f.ly = 16'(ly);
		f.rx = 16'(rx);
		f.ry = 16'(ry);
		f.lt = 8'(lt);
		f.rt = 8'(rt);
		return f;
	endfunction

	function automatic logic signed [AXIS_W-1:0] pick_axis(logic signed [AXIS_W-1:0] prev);
		int dz;
		int off;
		dz = int'(board.stick_dz);
		off = $urandom_range(0, 2);
		case ($urandom_range(0, 7))
			0: return prev;
			1: return 16'(dz + off - 1);
			2: return 16'(-dz - off + 1);
			3: begin
				case ($urandom_range(0, 3))
					0: return AXIS_MIN;
					1: return AXIS_MIN_CLP;
					2: return 16'sh7fff;
					default: return '0;
				endcase
			end
			4: return 16'(int'($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [TRG_W-1:0] pick_trig(logic [TRG_W-1:0] prev);
		case ($urandom_range(0, 5))
			0: return prev;
			1: return board.trig_dz + 8'($urandom_range(0, 2)) - 8'd1;
			2: return '0;
			3: return '1;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic run_phase(int count, logic [DZ_W-1:0] sdz, logic [TRG_W-1:0] tdz,
			bit idling, bit hold);
		poll_frame_t f;
		set_dead_zones(sdz, tdz);
		tx_idle = idling;
		rx_idle = idling;
		for (int n = 0; n < count; n++) begin
			if (hold && n == count / 2) hold_asked++;
			f.poll_ok = $urandom_range(0, 9) != 0;
			case ($urandom_range(0, 3))
				0: f.buttons = last_poll.buttons;
				1: f.buttons = last_poll.buttons ^ (16'd1 << $urandom_range(0, 15));
				2: f.buttons = last_poll.buttons ^ 16'($urandom & $urandom);
				default: f.buttons = 16'($urandom);
			endcase
			f.lx = pick_axis(last_poll.lx);
			f.ly = pick_axis(last_poll.ly);
			f.rx = pick_axis(last_poll.rx);
			f.ry = pick_axis(last_poll.ry);
			f.lt = pick_trig(last_poll.lt);
			f.rt = pick_trig(last_poll.rt);
			last_poll = f;
			send_poll(f);
		end
	endtask

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_poll(poll_of(1, 16'h0000, 0, 0, 0, 0, 0, 0));
		send_poll(poll_of(1, 16'hffff, 32767, 32767, 32767, 32767, 255, 255));
		send_poll(poll_of(1, 16'hffff, 32767, 32767, 32767, 32767, 255, 255));
		send_poll(poll_of(0, 16'h1234, -5, -5, -5, -5, 0, 0));
		send_poll(poll_of(1, 16'h0000, 0, 0, 0, 0, 61, 62));
		send_poll(poll_of(1, 16'h5555, -32768, -32768, -32768, -32768, 62, 61));
		send_poll(poll_of(1, 16'haaaa, 7864, -7864, 7864, -7864, 0, 0));
		send_poll(poll_of(1, 16'h8001, 7865, -7865, -7865, 7865, 0, 255));
		send_poll(poll_of(1, 16'h7ffe, 100, 20000, -20000, 5, 1, 254));
		send_poll(poll_of(1, 16'h0000, 100, -100, 7000, 7000, 0, 0));
		send_poll(poll_of(0, 16'hffff, 32767, 32767, 32767, 32767, 255, 255));
		send_poll(poll_of(1, 16'h0000, -32767, 32767, -32767, 32767, 0, 0));

		set_dead_zones(15'd32767, 8'd255);
		send_poll(poll_of(1, 16'h0f0f, -32768, -32768, -32768, -32768, 255, 255));
		send_poll(poll_of(1, 16'hf0f0, 32767, -32767, 32767, -32767, 254, 0));
		send_poll(poll_of(1, 16'h0000, -32768, 0, 0, -32768, 0, 255));

		set_dead_zones(15'd0, 8'd0);
		send_poll(poll_of(1, 16'h0000, 0, 0, 0, 0, 0, 0));
		send_poll(poll_of(1, 16'hffff, 1, -1, -1, 1, 1, 1));
		send_poll(poll_of(1, 16'h0000, 0, 1, 0, -1, 0, 1));

		run_phase(200, 15'd7864, 8'd61, 1, 0);
		run_phase(200, 15'd0, 8'd0, 1, 1);
		run_phase(200, 15'd32767, 8'd255, 1, 0);
		run_phase(200, 15'($urandom), 8'($urandom), 1, 0);
		run_phase(150, 15'($urandom_range(0, 255)), 8'($urandom), 0, 0);
		run_phase(200, 15'd1, 8'd254, 1, 0);
		run_phase(200, 15'($urandom), 8'($urandom), 1, 1);
		run_phase(200, 15'd7864, 8'd61, 0, 0);

		wait_drained();
		$display("%0d poll frames sent (%0d failed polls) across %0d dead zone settings",
			board.polls, board.failed_polls, settings);
		$display("%0d reports matched, %0d mismatches, %0d cycles",
			board.reports_ok, board.errors, cycle_count);
		if (board.errors == 0) begin
			$display("PASS gamepad_input_conditioner_unit");
		end else begin
			$display("FAIL gamepad_input_conditioner_unit");
		end
		$finish;
	end

endmodule
